// ===== rtl/rqwm_pkg.sv =====
`default_nettype none

package rqwm_pkg;

    // field widths
    localparam int MODE_W   = 1;
    localparam int HEIGHT_W = 10;
    localparam int TAG_W    = 16;
    localparam int KIND_W   = 2;
    localparam int OCC_W    = 3;

    localparam int SLOTS_DEF = 6;

    // stream words, padded to whole bytes
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;

    localparam logic [MODE_W-1:0] MODE_INSERT = 1'b0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 1'b1;

    localparam logic [KIND_W-1:0] KIND_MEAN    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_ROUND = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/rqwm_ram.sv =====
`default_nettype none

module rqwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/ring_queue_window_mean.sv =====
// ring_queue_window_mean: circular queue of SLOTS slots holding up to SLOTS-1
// entries (tag + height), with a running mean of the stored heights.
//
// Request side (s_*): one request per accepted s_tdata word.
//   mode 0 inserts {tag, height}; when full, the oldest entry is evicted first.
//   mode 1 removes the oldest entry.
// Result side (m_*): exactly one result per request, in request order.
//   kind 0: value = mean height after insert, rounded to nearest, ties to even.
//   kind 1: value/out_tag = removed entry.  kind 2: queue was empty, no change.
//   occupancy = entries held after the request.
//
// Timing: one request at a time; s_tready is high only while idle. A remove
// steps through accept, head read and result load. An insert steps through
// accept and head read, then divides a running sum by the count in a
// restoring divider, one quotient bit per cycle (SUM_W = 10 + clog2(SLOTS)
// steps), then a rounding step and the result load.
// A result waits in the output register while m_tready is low; a finished
// request holds in its last state until the register frees up.
// Reset empties the queue (head, tail, count, sum cleared); slot contents are
// not cleared, since only written slots are ever read.

`default_nettype none

module ring_queue_window_mean
    import rqwm_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,  // [0] mode, [10:1] height, [26:11] tag
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata   // [1:0] kind, [11:2] value,
                                               // [27:12] out_tag, [30:28] occupancy
);

    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS);
    localparam int SUM_W   = HEIGHT_W + CNT_W;
    localparam int STEP_W  = $clog2(SUM_W);
    localparam int ENTRY_W = TAG_W + HEIGHT_W;

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(SLOTS - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    // control
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // payload
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic [SUM_W-1:0]    dvd_reg, dvd_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [KIND_W-1:0]   res_kind_reg, res_kind_next;
    logic [HEIGHT_W-1:0] res_value_reg, res_value_next;
    logic [TAG_W-1:0]    res_tag_reg, res_tag_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // slot RAM
    logic                ram_we;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [HEIGHT_W-1:0] rd_height;
    logic [TAG_W-1:0]    rd_tag;

    // divider step
    logic [CNT_W:0]      div_shift;
    logic                div_ge;
    logic [CNT_W:0]      div_sub;
    logic [CNT_W:0]      twice_rem;
    logic                round_up;
    logic [SUM_W-1:0]    quot_inc;

    logic in_accept;
    logic out_free;
    logic full;

    rqwm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .raddr (head_reg),   // head entry always on the read port
        .rdata (ram_rdata)
    );

    assign ram_wdata = {tag_reg, height_reg};
    assign rd_height = ram_rdata[HEIGHT_W-1:0];
    assign rd_tag    = ram_rdata[ENTRY_W-1:HEIGHT_W];
    assign ram_we    = (state_reg == ST_READ) && (mode_reg == MODE_INSERT);

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign full      = (count_reg == FULL_CNT);

    // restoring division, one quotient bit per cycle; divisor is count_reg
    assign div_shift = {rem_reg, dvd_reg[SUM_W-1]};
    assign div_ge    = (div_shift >= {1'b0, count_reg});
    assign div_sub   = div_shift - {1'b0, count_reg};

    // round half to even
    assign twice_rem = {rem_reg, 1'b0};
    assign round_up  = (twice_rem > {1'b0, count_reg})
                    || ((twice_rem == {1'b0, count_reg}) && dvd_reg[0]);
    assign quot_inc  = dvd_reg + SUM_W'(round_up);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        step_next      = step_reg;
        m_tvalid_next  = m_tvalid_reg;
        mode_next      = mode_reg;
        height_next    = height_reg;
        tag_next       = tag_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        res_kind_next  = res_kind_reg;
        res_value_next = res_value_reg;
        res_tag_next   = res_tag_reg;
        m_tdata_next   = m_tdata_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    mode_next   = s_tdata[0];
                    height_next = s_tdata[10:1];
                    tag_next    = s_tdata[26:11];
                    state_next  = ST_READ;
                end
            end

            ST_READ:
            begin
                // ram_rdata holds the head entry here
                if (mode_reg == MODE_INSERT)
                begin
                    tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
                    if (full)
                    begin
                        head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                        sum_next  = sum_reg - SUM_W'(rd_height) + SUM_W'(height_reg);
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        sum_next   = sum_reg + SUM_W'(height_reg);
                    end
                    dvd_next      = sum_next;
                    rem_next      = '0;
                    step_next     = '0;
                    res_kind_next = KIND_MEAN;
                    res_tag_next  = '0;
                    state_next    = ST_DIV;
                end
                else if (count_reg == '0)
                begin
                    res_kind_next  = KIND_EMPTY;
                    res_value_next = '0;
                    res_tag_next   = '0;
                    state_next     = ST_FIN;
                end
                else
                begin
                    head_next      = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                    count_next     = count_reg - 1'b1;
                    sum_next       = sum_reg - SUM_W'(rd_height);
                    res_kind_next  = KIND_REMOVED;
                    res_value_next = rd_height;
                    res_tag_next   = rd_tag;
                    state_next     = ST_FIN;
                end
            end

            ST_DIV:
            begin
                rem_next  = div_ge ? div_sub[CNT_W-1:0] : div_shift[CNT_W-1:0];
                dvd_next  = {dvd_reg[SUM_W-2:0], div_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_ROUND;
                end
            end

            ST_ROUND:
            begin
                res_value_next = quot_inc[HEIGHT_W-1:0];
                state_next     = ST_FIN;
            end

            ST_FIN:
            begin
                if (out_free)
                begin
                    m_tdata_next  = {1'b0, OCC_W'(count_reg), res_tag_reg,
                                     res_value_reg, res_kind_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        height_reg    <= height_next;
        tag_reg       <= tag_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        res_kind_reg  <= res_kind_next;
        res_value_reg <= res_value_next;
        res_tag_reg   <= res_tag_next;
        m_tdata_reg   <= m_tdata_next;
    end

endmodule

`default_nettype wire

// ===== bench/ring_queue_window_mean_tb.sv =====
`timescale 1ns / 1ps

// Stream testbench for ring_queue_window_mean.
// Each accepted request steps a local model of the ring (six slots, five
// entries at most) and queues the result it should produce. Results are
// popped in order and compared per field. Both sides idle at random, apart
// from one full-rate stretch.

module ring_queue_window_mean_tb;
    import rqwm_pkg::*;

    localparam int DEPTH = SLOTS_DEF;

    // one result word, unpacked
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HEIGHT_W-1:0] value;
        logic [TAG_W-1:0]    out_tag;
        logic [OCC_W-1:0]    occupancy;
    } result_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // [0] mode, [10:1] height, [26:11] tag
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // [1:0] kind, [11:2] value,
                                    // [27:12] out_tag, [30:28] occupancy

    ring_queue_window_mean #(
        .SLOTS(DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // local copy of the ring
    logic [HEIGHT_W-1:0] ring_height [DEPTH];
    logic [TAG_W-1:0]    ring_tag    [DEPTH];
    int unsigned         ring_head;
    int unsigned         ring_tail;

    // results owed by the block, oldest first
    result_t pending_results[$];

    int  error_count;
    int  checked_count;
    int  insert_count;
    int  remove_count;
    int  empty_count;
    int  evict_count;
    bit  full_rate;   // no idling on either side while set

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Sends one request after a random gap, then steps the ring model at the
    // accepting edge. tvalid stays high on return, so a zero gap on the next
    // request gives back-to-back requests.
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic [HEIGHT_W-1:0] height,
                                input logic [TAG_W-1:0] tag);
        int          gap;
        int unsigned sum;
        int unsigned cnt;
        int unsigned quo;
        int unsigned rem;
        int unsigned idx;
        result_t     owed;
        gap = full_rate ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - MODE_W - HEIGHT_W - TAG_W){1'b0}}, tag, height, mode};
        @(posedge clk);
        while (!s_tready) @(posedge clk);

        owed = '0;
        if (mode == MODE_INSERT)
        begin
            // full ring: drop the oldest entry first
            if ((ring_tail + 1) % DEPTH == ring_head)
            begin
                ring_head = (ring_head + 1) % DEPTH;
                evict_count++;
            end
            ring_height[ring_tail] = height;
            ring_tag[ring_tail]    = tag;
            ring_tail = (ring_tail + 1) % DEPTH;
            sum = 0;
            cnt = 0;
            for (idx = ring_head; idx != ring_tail; idx = (idx + 1) % DEPTH)
            begin
                sum += ring_height[idx];
                cnt++;
            end
            // round to nearest, exact half goes to the even quotient
            quo = sum / cnt;
            rem = sum % cnt;
            if (2 * rem > cnt || (2 * rem == cnt && quo[0]))
                quo++;
            owed.kind  = KIND_MEAN;
            owed.value = quo[HEIGHT_W-1:0];
            insert_count++;
        end
        else if (ring_head == ring_tail)
        begin
            owed.kind = KIND_EMPTY;   // nothing held, nothing changes
            empty_count++;
        end
        else
        begin
            owed.kind    = KIND_REMOVED;
            owed.value   = ring_height[ring_head];
            owed.out_tag = ring_tag[ring_head];
            ring_head    = (ring_head + 1) % DEPTH;
            remove_count++;
        end
        owed.occupancy = OCC_W'((ring_tail + DEPTH - ring_head) % DEPTH);
        pending_results.push_back(owed);
    endtask

    // Holds off new requests until every owed result is back.
    // Always spends at least one edge so tvalid is never lowered and raised
    // in the same step.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    function automatic logic [HEIGHT_W-1:0] pick_height();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return '1;
        else
            return HEIGHT_W'($urandom_range(0, 1023));
    endfunction

    // Edge cases: remove on empty, extreme heights and tags, fill to full,
    // insert on full ring, drain, half-way means in both directions.
    task automatic test_directed_cases();
        send_request(MODE_REMOVE, '0, '0);                  // empty ring
        send_request(MODE_INSERT, 10'd0, 16'h0000);
        send_request(MODE_INSERT, 10'd1023, 16'hFFFF);      // 511.5 -> 512
        send_request(MODE_INSERT, 10'd1023, 16'hAAAA);
        send_request(MODE_INSERT, 10'd1023, 16'h5555);
        send_request(MODE_INSERT, 10'd1023, 16'h8001);      // now full
        send_request(MODE_INSERT, 10'd1023, 16'h7FFE);      // evicts the zero
        repeat (5) send_request(MODE_REMOVE, '1, '1);       // payload ignored
        send_request(MODE_REMOVE, 10'h2AA, 16'hA5A5);       // empty again
        send_request(MODE_INSERT, 10'd2, 16'h1234);
        send_request(MODE_INSERT, 10'd3, 16'h4321);         // 2.5 -> 2
        send_request(MODE_INSERT, 10'd5, 16'h0F0F);
        send_request(MODE_INSERT, 10'd4, 16'hF0F0);         // 3.5 -> 4
        send_request(MODE_REMOVE, '0, '0);
        send_request(MODE_INSERT, 10'd1, 16'h0001);
        send_request(MODE_INSERT, 10'd0, 16'h8000);
        send_request(MODE_INSERT, 10'h155, 16'hCAFE);       // full, evicts
        send_request(MODE_INSERT, 10'h2AA, 16'h3C3C);
        wait_for_results();
    endtask

    // Chunks with different insert/remove mixes so the ring spends time
    // empty, part full and full; some chunks end by waiting for every owed result.
    task automatic test_mixed_random(input int n);
        int insert_pct;
        int i;
        for (i = 0; i < n; i++)
        begin
            if (i % 50 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: insert_pct = 15;
                    1: insert_pct = 50;
                    2: insert_pct = 80;
                    default: insert_pct = 97;
                endcase
                if (i != 0 && $urandom_range(0, 3) == 0)
                    wait_for_results();
            end
            if ($urandom_range(0, 99) < insert_pct)
                send_request(MODE_INSERT, pick_height(), TAG_W'($urandom()));
            else
                send_request(MODE_REMOVE, pick_height(), TAG_W'($urandom()));
        end
    endtask

    // Random inserts and removes with no idling on either side.
    task automatic test_back_to_back(input int n);
        int i;
        full_rate = 1'b1;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 60)
                send_request(MODE_INSERT, pick_height(), TAG_W'($urandom()));
            else
                send_request(MODE_REMOVE, pick_height(), TAG_W'($urandom()));
        end
        full_rate = 1'b0;
    endtask

    // Small heights make exact half-way means common, for the even counts.
    task automatic test_tie_rounding(input int n);
        int i;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 85)
                send_request(MODE_INSERT, HEIGHT_W'($urandom_range(0, 3)),
                             TAG_W'($urandom()));
            else
                send_request(MODE_REMOVE, '0, '0);
        end
    endtask

    // Result side: random stall before each result, then compare with the
    // oldest owed result.
    initial
    begin : result_check
        int      stall;
        result_t got;
        result_t owed;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = full_rate ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);

            got.kind      = m_tdata[1:0];
            got.value     = m_tdata[11:2];
            got.out_tag   = m_tdata[27:12];
            got.occupancy = m_tdata[30:28];
            checked_count++;
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("[%0t] unexpected result: kind %0d value %0d tag %h occ %0d",
                             $realtime, got.kind, got.value, got.out_tag, got.occupancy);
            end
            else
            begin
                owed = pending_results.pop_front();
                if (got.kind !== owed.kind || got.value !== owed.value ||
                    got.out_tag !== owed.out_tag || got.occupancy !== owed.occupancy)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"[%0t] mismatch: expected kind %0d value %0d tag %h occ %0d,",
                                  " got kind %0d value %0d tag %h occ %0d"},
                                 $realtime, owed.kind, owed.value, owed.out_tag,
                                 owed.occupancy, got.kind, got.value, got.out_tag,
                                 got.occupancy);
                end
            end
        end
    end

    // Runaway guard, far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        error_count   = 0;
        checked_count = 0;
        insert_count  = 0;
        remove_count  = 0;
        empty_count   = 0;
        evict_count   = 0;
        full_rate     = 1'b0;
        ring_head     = 0;
        ring_tail     = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_mixed_random(750);
        wait_for_results();
        test_back_to_back(250);
        wait_for_results();
        test_tie_rounding(250);
        wait_for_results();
        // leave room for any stray result
        repeat (60) @(posedge clk);

        $display("Covered %0d inserts (%0d evicting), %0d removes, %0d removes on empty ring",
                 insert_count, evict_count, remove_count, empty_count);
        $display("%0d results checked, %0d errors", checked_count, error_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== ring_queue_window_mean.f =====
rtl/rqwm_pkg.sv
rtl/rqwm_ram.sv
rtl/ring_queue_window_mean.sv
bench/ring_queue_window_mean_tb.sv
